// ----- hw/rtl/afr_pkg.sv -----
// Shared types, widths, codes and helpers for the animation frame timer.
`default_nettype none
package afr_pkg;

    localparam int CMD_W       = 3;
    localparam int TS_W        = 32;
    localparam int IDX_W       = 8;
    localparam int DELAY_W     = 20;
    localparam int FCOUNT_W    = 9;
    localparam int TOT_W       = DELAY_W + FCOUNT_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int MAX_FRAMES_DEF = 256;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;

    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_LOOP_ENABLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_MOD,
        S_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [TS_W-1:0]   dividend;
        logic [TOT_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [TOT_W-1:0]  rem;
    } t_mod_rsp;

    function automatic logic [DELAY_W-1:0] fix_delay(input logic [DELAY_W-1:0] d);
        return (d == '0) ? DELAY_W'(1) : d;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/afr_if.sv -----
// Valid/ready channel interfaces for command beats and status beats.
`default_nettype none
interface afr_in_if;
    import afr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [TS_W-1:0]      now_ms;
    logic [IDX_W-1:0]     write_index;
    logic [DELAY_W-1:0]   delay_value;

    modport source (output valid, cmd, now_ms, write_index, delay_value, input ready);
    modport sink (input valid, cmd, now_ms, write_index, delay_value, output ready);
endinterface

interface afr_out_if;
    logic        valid;
    logic        ready;
    logic        playing;
    logic        paused;
    logic [7:0]  frame_index;
    logic        frame_changed;
    logic        reached_end;

    modport source (output valid, playing, paused, frame_index, frame_changed, reached_end,
                    input ready);
    modport sink (input valid, playing, paused, frame_index, frame_changed, reached_end,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/animation_frame_timer.sv -----
// Animation frame timer top level: command sequencer, config registers and delay table.
// Every command beat yields one status beat. Write, play, stop, pause, resume, unknown
// commands and ignored ticks go straight from idle to the done state. An active tick
// re-sums the frame delays first when a delay or register was written since the last
// sum, then steps one frame at a time (one delay table read port), and when the
// accumulated time covers a whole loop the bit-serial remainder unit folds it down.
// A beat waits in the output register while the next command is taken.
`default_nettype none
module animation_frame_timer #(
    parameter int MAX_FRAMES = afr_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    afr_in_if.sink                               i_in,
    afr_out_if.source                            o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [afr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [afr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [afr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import afr_pkg::*;

    localparam int FRM_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = FRM_W + 1;

    t_state               r_state, n_state;
    logic [FCOUNT_W-1:0]  r_frame_count;
    logic                 r_loop;
    logic [FRM_W-1:0]     r_cf, n_cf;
    logic [TS_W-1:0]      r_acc, n_acc;
    logic [TS_W-1:0]      r_last, n_last;
    logic                 r_active, n_active;
    logic                 r_pause, n_pause;
    logic                 r_changed, n_changed;
    logic                 r_ended, n_ended;
    logic [TOT_W-1:0]     r_total, n_total;
    logic                 r_dirty, n_dirty;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_playing, r_out_paused, r_out_changed, r_out_ended;
    logic [7:0]           r_out_frame;

    logic                 w_accept;
    logic                 w_cfg_wr;
    logic [CNT_W-1:0]     w_count;
    logic [TS_W-1:0]      w_elapsed;
    logic [TS_W:0]        w_sum;
    logic [TS_W-1:0]      w_acc_sat;
    logic                 w_tick_run;
    logic                 w_mod_go;
    logic [DELAY_W-1:0]   w_rdata;
    logic [DELAY_W-1:0]   w_d;
    logic [CNT_W-1:0]     w_next;
    logic                 w_short;
    logic                 w_end_stop;
    logic                 w_step_done;
    logic                 w_out_load;
    logic                 w_we;
    logic [FRM_W-1:0]     w_raddr;
    t_mod_req             w_mod_req;
    t_mod_rsp             w_mod_rsp;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_LOOP_ENABLE) ? APB_DATA_W'(r_loop)
                                                    : APB_DATA_W'(r_frame_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_loop        <= 1'b1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_FRAME_COUNT) begin
                r_frame_count <= pwdata[FCOUNT_W-1:0];
            end else begin
                r_loop <= pwdata[0];
            end
        end
    end

    assign w_count = (32'(r_frame_count) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                            : CNT_W'(r_frame_count);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_elapsed  = i_in.now_ms - r_last;
    assign w_sum      = {1'b0, r_acc} + {1'b0, w_elapsed};
    assign w_acc_sat  = w_sum[TS_W] ? '1 : w_sum[TS_W-1:0];
    assign w_tick_run = (i_in.cmd == CMD_TICK) && r_active && !r_pause && (w_count != '0);

    assign w_we    = w_accept && (i_in.cmd == CMD_WRITE)
                     && (32'(i_in.write_index) < 32'(MAX_FRAMES));
    assign w_raddr = (r_state == S_SUM) ? r_idx[FRM_W-1:0] : r_cf;

    afr_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (MAX_FRAMES),
        .ADDR_W(FRM_W)
    ) u_delay_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(FRM_W'(i_in.write_index)),
        .i_wdata(i_in.delay_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_d        = fix_delay(w_rdata);
    assign w_mod_go   = r_loop && ({1'b0, r_cf} < w_count) && (r_acc >= TS_W'(r_total));
    assign w_next     = {1'b0, r_cf} + CNT_W'(1);
    assign w_short    = (r_acc < TS_W'(w_d));
    assign w_end_stop = (w_next >= w_count) && !r_loop;
    assign w_step_done = w_short || w_end_stop;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign w_mod_req.start    = (r_state == S_CHECK) && w_mod_go;
    assign w_mod_req.dividend = r_acc;
    assign w_mod_req.divisor  = r_total;

    afr_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mod_req),
        .o_rsp  (w_mod_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_tick_run) begin
                        n_state = r_dirty ? S_SUM : S_CHECK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SUM: begin
                if ((r_idx == w_count) && !r_pend) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_mod_go ? S_MOD : S_STEP;
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_STEP: begin
                n_state = w_step_done ? S_DONE : S_CHECK;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cf      = r_cf;
        n_acc     = r_acc;
        n_last    = r_last;
        n_active  = r_active;
        n_pause   = r_pause;
        n_changed = r_changed;
        n_ended   = r_ended;
        n_total   = r_total;
        n_dirty   = r_dirty;
        n_idx     = r_idx;
        n_pend    = r_pend;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_changed = 1'b0;
                    n_ended   = 1'b0;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_total   = r_dirty ? '0 : r_total;
                    case (i_in.cmd)
                        CMD_TICK: begin
                            if (r_active && !r_pause) begin
                                n_acc  = w_acc_sat;
                                n_last = i_in.now_ms;
                                if (w_count == '0) begin
                                    n_active = 1'b0;
                                    n_pause  = 1'b0;
                                end
                            end
                        end
                        CMD_PLAY: begin
                            if (w_count != '0) begin
                                n_acc    = '0;
                                n_last   = i_in.now_ms;
                                n_cf     = '0;
                                n_active = 1'b1;
                                n_pause  = 1'b0;
                            end
                        end
                        CMD_STOP: begin
                            n_active = 1'b0;
                            n_pause  = 1'b0;
                        end
                        CMD_PAUSE: begin
                            if (r_active) begin
                                n_pause = 1'b1;
                            end
                        end
                        CMD_RESUME: begin
                            if (r_active && r_pause) begin
                                n_last  = i_in.now_ms;
                                n_pause = 1'b0;
                            end
                        end
                        CMD_WRITE: begin
                            n_dirty = 1'b1;
                        end
                        default: begin
                            n_dirty = r_dirty;
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (r_pend) begin
                    n_total = r_total + TOT_W'(w_d);
                end
                if (r_idx != w_count) begin
                    n_idx  = r_idx + CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_dirty = 1'b0;
                    end
                end
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    n_acc     = TS_W'(w_mod_rsp.rem);
                    n_changed = 1'b1;
                end
            end
            S_STEP: begin
                if (!w_short) begin
                    n_acc = r_acc - TS_W'(w_d);
                    if (w_next >= w_count) begin
                        if (!r_loop) begin
                            n_cf      = FRM_W'(w_count - CNT_W'(1));
                            n_active  = 1'b0;
                            n_pause   = 1'b0;
                            n_ended   = 1'b1;
                            n_changed = 1'b0;
                        end else begin
                            n_cf      = '0;
                            n_changed = 1'b1;
                        end
                    end else begin
                        n_cf      = w_next[FRM_W-1:0];
                        n_changed = 1'b1;
                    end
                end
            end
            default: begin
                n_cf = r_cf;
            end
        endcase
        if (w_cfg_wr) begin
            n_dirty = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cf        <= '0;
            r_acc       <= '0;
            r_last      <= '0;
            r_active    <= 1'b0;
            r_pause     <= 1'b0;
            r_changed   <= 1'b0;
            r_ended     <= 1'b0;
            r_dirty     <= 1'b1;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cf        <= n_cf;
            r_acc       <= n_acc;
            r_last      <= n_last;
            r_active    <= n_active;
            r_pause     <= n_pause;
            r_changed   <= n_changed;
            r_ended     <= n_ended;
            r_dirty     <= n_dirty;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        if (w_out_load) begin
            r_out_playing <= r_active;
            r_out_paused  <= r_pause;
            r_out_frame   <= 8'(r_cf);
            r_out_changed <= r_changed;
            r_out_ended   <= r_ended;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.playing       = r_out_playing;
    assign o_out.paused        = r_out_paused;
    assign o_out.frame_index   = r_out_frame;
    assign o_out.frame_changed = r_out_changed;
    assign o_out.reached_end   = r_out_ended;

endmodule
`default_nettype wire

// ----- hw/rtl/afr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module afr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/afr_mod.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module afr_mod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire afr_pkg::t_mod_req i_req,
    output afr_pkg::t_mod_rsp      o_rsp
);
    import afr_pkg::*;

    localparam int CNT_W = $clog2(TS_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TS_W-1:0]  r_dvd, n_dvd;
    logic [TOT_W-1:0] r_rem, n_rem;
    logic [TOT_W-1:0] r_div, n_div;
    logic [TOT_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_dvd[TS_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? TOT_W'(w_trial - {1'b0, r_div}) : w_trial[TOT_W-1:0];
            n_dvd = {r_dvd[TS_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(TS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the animation frame timer: directed table, random phases, predictor.
module testbench;
    import afr_pkg::*;

    typedef struct packed {
        logic       playing;
        logic       paused;
        logic [7:0] frame_index;
        logic       frame_changed;
        logic       reached_end;
    } t_status;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [CMD_W-1:0]    cmd;
        logic [TS_W-1:0]     now_ms;
        logic [IDX_W-1:0]    idx;
        logic [DELAY_W-1:0]  value;
        bit                  typed;
        t_status             status;
    } t_plan_row;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
    localparam t_status ST_STOPPED = '0;
    localparam t_status ST_STARTED = t_status'{1'b1, 1'b0, 8'd0, 1'b0, 1'b0};
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 160;
    localparam int NUM_PHASES  = 10;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    afr_in_if  cmd_bus ();
    afr_out_if sts_bus ();

    animation_frame_timer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (sts_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_status             status_expected[$];
    t_plan_row           plan[$];
    int                  errors;
    int                  src_idle;
    int                  snk_idle;
    bit                  hold_req;
    int                  stall_left;
    int                  live_items;
    logic [TS_W-1:0]     clk_ms;

    logic [DELAY_W-1:0]  pr_delay [0:MAX_FRAMES_DEF-1];
    int                  pr_frame;
    logic [31:0]         pr_acc;
    logic [31:0]         pr_stamp;
    bit                  pr_run;
    bit                  pr_hold;
    logic [FCOUNT_W-1:0] pr_count_reg;
    bit                  pr_loop_reg;

    int phase_count [NUM_PHASES] = '{4, 2, 1, 256, 6, 0, 3, 300, 8, 5};
    bit phase_loop  [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #120000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [31:0] effective_delay(input int i);
        return (pr_delay[i] == '0) ? 32'd1 : {12'd0, pr_delay[i]};
    endfunction

    function automatic t_status advance_player(input logic [CMD_W-1:0] cmd,
                                               input logic [TS_W-1:0] now,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [DELAY_W-1:0] value);
        t_status     st;
        logic [31:0] elapsed;
        logic [31:0] step;
        logic [63:0] total;
        int          cnt;
        bit          changed;
        bit          ended;
        changed = 1'b0;
        ended = 1'b0;
        cnt = (pr_count_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(pr_count_reg);
        case (cmd)
            CMD_WRITE: pr_delay[idx] = value;
            CMD_PLAY: begin
                if (cnt != 0) begin
                    pr_acc = '0;
                    pr_stamp = now;
                    pr_frame = 0;
                    pr_run = 1'b1;
                    pr_hold = 1'b0;
                end
            end
            CMD_STOP: begin
                pr_run = 1'b0;
                pr_hold = 1'b0;
            end
            CMD_PAUSE: begin
                if (pr_run) pr_hold = 1'b1;
            end
            CMD_RESUME: begin
                if (pr_run && pr_hold) begin
                    pr_stamp = now;
                    pr_hold = 1'b0;
                end
            end
            CMD_TICK: begin
                if (pr_run && !pr_hold) begin
                    elapsed = now - pr_stamp;
                    pr_acc = (pr_acc > ~elapsed) ? '1 : pr_acc + elapsed;
                    pr_stamp = now;
                    if (cnt == 0) begin
                        pr_run = 1'b0;
                        pr_hold = 1'b0;
                    end else begin
                        total = '0;
                        for (int i = 0; i < cnt; i++) total += effective_delay(i);
                        while (1'b1) begin
                            // All whole loops of the animation are folded away in one go.
                            if (pr_loop_reg && pr_frame < cnt && {32'd0, pr_acc} >= total) begin
                                pr_acc = 32'({32'd0, pr_acc} % total);
                                changed = 1'b1;
                            end
                            step = effective_delay(pr_frame);
                            if (pr_acc < step) break;
                            pr_acc -= step;
                            pr_frame++;
                            if (pr_frame >= cnt) begin
                                if (!pr_loop_reg) begin
                                    pr_frame = cnt - 1;
                                    pr_run = 1'b0;
                                    pr_hold = 1'b0;
                                    ended = 1'b1;
                                    changed = 1'b0;
                                    break;
                                end
                                pr_frame = 0;
                            end
                            changed = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        st.playing = pr_run;
        st.paused = pr_hold;
        st.frame_index = pr_frame[7:0];
        st.frame_changed = changed;
        st.reached_end = ended;
        return st;
    endfunction

    function automatic logic [TS_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0: clk_ms = $urandom;
            1: clk_ms = clk_ms - $urandom_range(1, 5);
            2: clk_ms = clk_ms + $urandom_range(0, 5000);
            default: clk_ms = clk_ms + $urandom_range(0, 12);
        endcase
        return clk_ms;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [CMD_W-1:0] cmd,
                                    input logic [TS_W-1:0] now, input logic [IDX_W-1:0] idx,
                                    input logic [DELAY_W-1:0] value, input bit typed,
                                    input t_status status);
        t_plan_row row;
        row.kind = kind;
        row.cmd = cmd;
        row.now_ms = now;
        row.idx = idx;
        row.value = value;
        row.typed = typed;
        row.status = status;
        plan.push_back(row);
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [TS_W-1:0] now,
                             input logic [IDX_W-1:0] idx, input logic [DELAY_W-1:0] value,
                             input bit typed, input t_status typed_status);
        t_status predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd <= cmd;
        cmd_bus.now_ms <= now;
        cmd_bus.write_index <= idx;
        cmd_bus.delay_value <= value;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        predicted = advance_player(cmd, now, idx, value);
        status_expected.push_back(typed ? typed_status : predicted);
    endtask

    task automatic drain_statuses();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (status_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        logic [APB_DATA_W-1:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (reg_sel == REG_FRAME_COUNT) begin
            pr_count_reg = value[FCOUNT_W-1:0];
            want = {{(APB_DATA_W-FCOUNT_W){1'b0}}, value[FCOUNT_W-1:0]};
        end else begin
            pr_loop_reg = value[0];
            want = {{(APB_DATA_W-1){1'b0}}, value[0]};
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        readback = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== want) begin
            $display("%0t: register %0d readback: expected %0d, got %0d",
                     $time, reg_sel, want, readback);
            errors++;
        end
    endtask

    initial begin
        sts_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                sts_bus.ready <= 1'b0;
            end else begin
                sts_bus.ready <= ($urandom_range(0, 99) >= snk_idle);
            end
        end
    end

    always @(posedge i_clk) begin : status_check
        t_status got;
        t_status want;
        if (i_rst_n === 1'b1 && sts_bus.valid === 1'b1 && sts_bus.ready === 1'b1) begin
            got = {sts_bus.playing, sts_bus.paused, sts_bus.frame_index,
                   sts_bus.frame_changed, sts_bus.reached_end};
            if (status_expected.size() == 0) begin
                $display("%0t: unexpected status beat: playing=%0b paused=%0b frame=%0d",
                         $time, got.playing, got.paused, got.frame_index);
                errors++;
            end else begin
                want = status_expected.pop_front();
                if (got !== want) begin
                    $display("%0t: status mismatch (playing paused frame changed end)",
                             $time);
                    $display("    expected %0b %0b %0d %0b %0b", want.playing, want.paused,
                             want.frame_index, want.frame_changed, want.reached_end);
                    $display("    got      %0b %0b %0d %0b %0b", got.playing, got.paused,
                             got.frame_index, got.frame_changed, got.reached_end);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [CMD_W-1:0]   cmd;
        logic [TS_W-1:0]    now;
        logic [IDX_W-1:0]   idx;
        logic [DELAY_W-1:0] value;
        int                 pick;
        int                 issued;
        int                 phase_live;
        bit                 ignored;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.cmd = CMD_TICK;
        cmd_bus.now_ms = '0;
        cmd_bus.write_index = '0;
        cmd_bus.delay_value = '0;
        errors = 0;
        src_idle = 22;
        snk_idle = 73;
        hold_req = 1'b0;
        stall_left = 0;
        live_items = 0;
        clk_ms = '0;
        pr_frame = 0;
        pr_acc = '0;
        pr_stamp = '0;
        pr_run = 1'b0;
        pr_hold = 1'b0;
        pr_count_reg = '0;
        pr_loop_reg = 1'b1;
        for (int i = 0; i < MAX_FRAMES_DEF; i++) pr_delay[i] = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every delay entry is written before anything can read it.
        for (int i = 0; i < MAX_FRAMES_DEF; i++)
            send_beat(CMD_WRITE, $urandom, 8'(i), 20'($urandom_range(0, 6)), 1'b0, ST_STOPPED);

        add_row(ROW_BEAT, CMD_TICK, 32'd0, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_PLAY, 32'd5, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_PAUSE, 32'd0, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_RESUME, 32'd100, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_STOP, 32'd0, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_RSVD_A, 32'hFFFF_FFFF, 8'hFF, 20'hFFFFF, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_RSVD_B, 32'd0, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_WRITE, 32'd0, 8'hFF, 20'hFFFFF, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_WRITE, 32'd0, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_WRITE, 32'd0, 8'd1, 20'd10, 1'b1, ST_STOPPED);
        add_row(ROW_BEAT, CMD_WRITE, 32'd0, 8'd2, 20'd20, 1'b1, ST_STOPPED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_FRAME_COUNT}, 20'd3, 1'b0, ST_STOPPED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_LOOP_ENABLE}, 20'd1, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_PLAY, 32'd1000, 8'd0, 20'd0, 1'b1, ST_STARTED);
        add_row(ROW_BEAT, CMD_TICK, 32'd1000, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd1001, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd1015, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_PAUSE, 32'd0, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd5000, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_RESUME, 32'd6000, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd6016, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd9116, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd9115, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_LOOP_ENABLE}, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd9200, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_PLAY, 32'd9300, 8'd0, 20'd0, 1'b1, ST_STARTED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_FRAME_COUNT}, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'd9400, 8'd0, 20'd0, 1'b1, ST_STOPPED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_FRAME_COUNT}, 20'd511, 1'b0, ST_STOPPED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_LOOP_ENABLE}, 20'd1, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_PLAY, 32'hFFFF_FFF0, 8'd0, 20'd0, 1'b1, ST_STARTED);
        add_row(ROW_BEAT, CMD_TICK, 32'h0000_0010, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_CFG, CMD_TICK, 32'd0, {7'd0, REG_FRAME_COUNT}, 20'd3, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_TICK, 32'h0000_0060, 8'd0, 20'd0, 1'b0, ST_STOPPED);
        add_row(ROW_BEAT, CMD_STOP, 32'd0, 8'd0, 20'd0, 1'b0, ST_STOPPED);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_statuses();
                cfg_write(plan[i].idx[0], {12'd0, plan[i].value});
            end else begin
                send_beat(plan[i].cmd, plan[i].now_ms, plan[i].idx, plan[i].value,
                          plan[i].typed, plan[i].status);
            end
        end
        clk_ms = 32'h0000_0060;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_statuses();
            cfg_write(REG_FRAME_COUNT, APB_DATA_W'(phase_count[p]));
            cfg_write(REG_LOOP_ENABLE, APB_DATA_W'(phase_loop[p]));
            issued = 0;
            phase_live = 0;
            while (phase_live < PHASE_ITEMS && issued < 3 * PHASE_ITEMS) begin
                if (live_items < 533) begin
                    src_idle = 22;
                    snk_idle = 73;
                end else if (live_items < 1067) begin
                    src_idle = 73;
                    snk_idle = 22;
                end else begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                pick = $urandom_range(0, 99);
                if (!pr_run && pick < 40) cmd = CMD_PLAY;
                else if (pick < 60) cmd = CMD_TICK;
                else if (pick < 70) cmd = CMD_WRITE;
                else if (pick < 76) cmd = CMD_PLAY;
                else if (pick < 83) cmd = CMD_PAUSE;
                else if (pick < 90) cmd = CMD_RESUME;
                else if (pick < 95) cmd = CMD_STOP;
                else cmd = ($urandom_range(0, 1) == 0) ? CMD_RSVD_A : CMD_RSVD_B;
                if (cmd == CMD_TICK || cmd == CMD_PLAY || cmd == CMD_RESUME) now = next_stamp();
                else now = $urandom;
                idx = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0) value = 20'($urandom_range(0, 20'hFFFFF));
                else value = 20'($urandom_range(0, 12));
                ignored = (cmd == CMD_TICK && !(pr_run && !pr_hold)) ||
                          cmd == CMD_RSVD_A || cmd == CMD_RSVD_B;
                send_beat(cmd, now, idx, value, 1'b0, ST_STOPPED);
                issued++;
                if (issued == 40) hold_req = 1'b1;
                if (!ignored) begin
                    phase_live++;
                    live_items++;
                end
            end
        end

        drain_statuses();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
